// File: hdl/lcdw_pkg.sv
// lcdw_pkg: types, codes and microcode ROM of the 4-bit character LCD writer.
// Used by lcdw_sequencer, lcdw_datapath and lcd_4bit_character_writer.
// No dependencies.
`timescale 1ns / 1ps

package lcdw_pkg;

   localparam int NUMBER_DIGITS_DEFAULT = 10;
   localparam int MAG_BITS = 32;
   localparam int PC_BITS = 5;

   localparam logic [2:0] ACT_INIT    = 3'd0;
   localparam logic [2:0] ACT_COMMAND = 3'd1;
   localparam logic [2:0] ACT_DATA    = 3'd2;
   localparam logic [2:0] ACT_GOTO    = 3'd3;
   localparam logic [2:0] ACT_NUMBER  = 3'd4;
   localparam logic [2:0] ACT_CLEAR   = 3'd5;

   localparam logic [7:0] ROW_MAX = 8'd4;
   localparam logic [7:0] COL_MAX = 8'd20;
   localparam logic [7:0] GOTO_DEFAULT = 8'h80;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

   // microprogram entry points
   localparam logic [PC_BITS-1:0] PC_INIT      = 5'd0;
   localparam logic [PC_BITS-1:0] PC_COMMAND   = 5'd10;
   localparam logic [PC_BITS-1:0] PC_DATA      = 5'd12;
   localparam logic [PC_BITS-1:0] PC_CLEAR     = 5'd14;
   localparam logic [PC_BITS-1:0] PC_NUMBER    = 5'd16;
   localparam logic [PC_BITS-1:0] PC_SIGN_TEST = 5'd17;
   localparam logic [PC_BITS-1:0] PC_SKIP      = 5'd20;
   localparam logic [PC_BITS-1:0] PC_DIGIT     = 5'd21;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         byte_value;
      logic signed [31:0] number_value;
      logic [7:0]         row;
      logic [7:0]         column;
   } req_word_type;

   typedef struct packed {
      logic       register_select;
      logic [3:0] nibble;
      logic [1:0] extra_wait_ms;
      logic       last;
   } rsp_word_type;

   typedef enum logic [1:0] {SRC_CONST, SRC_OPERAND, SRC_DIGIT} emit_src_type;
   typedef enum logic [1:0] {DP_NONE, DP_DABBLE, DP_SKIP, DP_NEXT_DIGIT} dp_op_type;
   typedef enum logic [2:0] {
      JMP_NEVER, JMP_BITS_LEFT, JMP_NOT_NEG, JMP_LEAD_ZERO, JMP_DIGITS_LEFT
   } jump_cond_type;
   typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_FINAL_DIGIT} last_mode_type;

   typedef struct packed {
      logic                emit;
      logic                half_lo;
      emit_src_type        src;
      logic                rs;
      logic [7:0]          konst;
      logic [1:0]          wait_ms;
      last_mode_type       last_mode;
      dp_op_type           dp_op;
      jump_cond_type       cond;
      logic [PC_BITS-1:0]  target;
      logic                done;
   } ctrl_word_type;

   typedef struct packed {
      logic bits_left;
      logic not_neg;
      logic lead_zero;
      logic digits_left;
   } dp_status_type;

   function automatic ctrl_word_type mk_cw(
      input logic emit, input logic half_lo, input emit_src_type src, input logic rs,
      input logic [7:0] konst, input logic [1:0] wait_ms, input last_mode_type last_mode,
      input dp_op_type dp_op, input jump_cond_type cond, input logic [PC_BITS-1:0] target,
      input logic done);
      ctrl_word_type cw;
      cw.emit      = emit;
      cw.half_lo   = half_lo;
      cw.src       = src;
      cw.rs        = rs;
      cw.konst     = konst;
      cw.wait_ms   = wait_ms;
      cw.last_mode = last_mode;
      cw.dp_op     = dp_op;
      cw.cond      = cond;
      cw.target    = target;
      cw.done      = done;
      return cw;
   endfunction

   // strobe step: hi = 0, lo = 1
   function automatic ctrl_word_type strobe_cw(
      input logic half_lo, input emit_src_type src, input logic rs, input logic [7:0] konst,
      input logic [1:0] wait_ms, input logic fin);
      return mk_cw(1'b1, half_lo, src, rs, konst, wait_ms, fin ? LAST_YES : LAST_NO,
                   DP_NONE, JMP_NEVER, PC_INIT, fin);
   endfunction

   localparam ctrl_word_type CW_NOP = '{
      emit: 1'b0, half_lo: 1'b0, src: SRC_CONST, rs: 1'b0, konst: 8'h00, wait_ms: 2'd0,
      last_mode: LAST_NO, dp_op: DP_NONE, cond: JMP_NEVER, target: 5'd0, done: 1'b1};

   function automatic ctrl_word_type microcode(input logic [PC_BITS-1:0] pc);
      ctrl_word_type cw;
      unique case (pc)
         5'd0:  cw = strobe_cw(1'b0, SRC_CONST, 1'b0, 8'h02, 2'd0, 1'b0);
         5'd1:  cw = strobe_cw(1'b1, SRC_CONST, 1'b0, 8'h02, 2'd0, 1'b0);
         5'd2:  cw = strobe_cw(1'b0, SRC_CONST, 1'b0, 8'h28, 2'd0, 1'b0);
         5'd3:  cw = strobe_cw(1'b1, SRC_CONST, 1'b0, 8'h28, 2'd1, 1'b0);
         5'd4:  cw = strobe_cw(1'b0, SRC_CONST, 1'b0, 8'h0F, 2'd0, 1'b0);
         5'd5:  cw = strobe_cw(1'b1, SRC_CONST, 1'b0, 8'h0F, 2'd1, 1'b0);
         5'd6:  cw = strobe_cw(1'b0, SRC_CONST, 1'b0, 8'h01, 2'd0, 1'b0);
         5'd7:  cw = strobe_cw(1'b1, SRC_CONST, 1'b0, 8'h01, 2'd2, 1'b0);
         5'd8:  cw = strobe_cw(1'b0, SRC_CONST, 1'b0, 8'h06, 2'd0, 1'b0);
         5'd9:  cw = strobe_cw(1'b1, SRC_CONST, 1'b0, 8'h06, 2'd0, 1'b1);
         5'd10: cw = strobe_cw(1'b0, SRC_OPERAND, 1'b0, 8'h00, 2'd0, 1'b0);
         5'd11: cw = strobe_cw(1'b1, SRC_OPERAND, 1'b0, 8'h00, 2'd0, 1'b1);
         5'd12: cw = strobe_cw(1'b0, SRC_OPERAND, 1'b1, 8'h00, 2'd0, 1'b0);
         5'd13: cw = strobe_cw(1'b1, SRC_OPERAND, 1'b1, 8'h00, 2'd0, 1'b1);
         5'd14: cw = strobe_cw(1'b0, SRC_CONST, 1'b0, 8'h01, 2'd0, 1'b0);
         5'd15: cw = strobe_cw(1'b1, SRC_CONST, 1'b0, 8'h01, 2'd2, 1'b1);
         5'd16: cw = mk_cw(1'b0, 1'b0, SRC_CONST, 1'b0, 8'h00, 2'd0, LAST_NO,
                           DP_DABBLE, JMP_BITS_LEFT, PC_NUMBER, 1'b0);
         5'd17: cw = mk_cw(1'b0, 1'b0, SRC_CONST, 1'b0, 8'h00, 2'd0, LAST_NO,
                           DP_NONE, JMP_NOT_NEG, PC_SKIP, 1'b0);
         5'd18: cw = strobe_cw(1'b0, SRC_CONST, 1'b1, CHAR_MINUS, 2'd0, 1'b0);
         5'd19: cw = strobe_cw(1'b1, SRC_CONST, 1'b1, CHAR_MINUS, 2'd0, 1'b0);
         5'd20: cw = mk_cw(1'b0, 1'b0, SRC_CONST, 1'b0, 8'h00, 2'd0, LAST_NO,
                           DP_SKIP, JMP_LEAD_ZERO, PC_SKIP, 1'b0);
         5'd21: cw = strobe_cw(1'b0, SRC_DIGIT, 1'b1, 8'h00, 2'd0, 1'b0);
         5'd22: cw = mk_cw(1'b1, 1'b1, SRC_DIGIT, 1'b1, 8'h00, 2'd0, LAST_FINAL_DIGIT,
                           DP_NEXT_DIGIT, JMP_DIGITS_LEFT, PC_DIGIT, 1'b1);
         default: cw = CW_NOP;
      endcase
      return cw;
   endfunction

   function automatic logic [PC_BITS-1:0] entry_point(input logic [2:0] action);
      logic [PC_BITS-1:0] pc;
      unique case (action)
         ACT_INIT:    pc = PC_INIT;
         ACT_COMMAND: pc = PC_COMMAND;
         ACT_DATA:    pc = PC_DATA;
         ACT_GOTO:    pc = PC_COMMAND;
         ACT_NUMBER:  pc = PC_NUMBER;
         ACT_CLEAR:   pc = PC_CLEAR;
         default:     pc = PC_INIT;
      endcase
      return pc;
   endfunction

   function automatic logic [7:0] goto_code(input logic [7:0] row, input logic [7:0] column);
      logic [7:0] base;
      logic [7:0] code;
      unique case (row[1:0])
         2'b01:   base = 8'h80;
         2'b10:   base = 8'hC0;
         2'b11:   base = 8'h90;
         default: base = 8'hD0;
      endcase
      if (row >= 8'd1 && row <= ROW_MAX && column >= 8'd1 && column <= COL_MAX) begin
         code = base + column - 8'd1;
      end else begin
         code = GOTO_DEFAULT;
      end
      return code;
   endfunction

endpackage

// File: hdl/lcd_4bit_character_writer.sv
// The step counter is loaded when start is taken; each word is read from its microcode step and
// registered at the outputs, one a cycle for init (10 words) and command/data/go-to/clear (2).
// A number runs the conversion steps, a sign test, both halves of '-' when negative, a skip step
// per dropped leading zero plus one, then two strobes per digit. busy covers every step; a new
// request is taken only while busy is low. Results cannot be held off. Synchronous reset clears the
// sequencer and the strobe. Top level: lcdw_sequencer and lcdw_datapath; depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcd_4bit_character_writer #(
   parameter int NUMBER_DIGITS = lcdw_pkg::NUMBER_DIGITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lcdw_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output lcdw_pkg::rsp_word_type rsp_word
);

   logic                    accept;
   lcdw_pkg::ctrl_word_type cw;
   lcdw_pkg::dp_status_type status;

   assign accept = start && !busy;

   lcdw_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .action (req_word.action),
      .status (status),
      .cw     (cw),
      .busy   (busy)
   );

   lcdw_datapath #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_word   (req_word),
      .cw         (cw),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// File: hdl/lcdw_sequencer.sv
// lcdw_sequencer: step counter and microcode ROM with conditional jumps.
// Depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcdw_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [2:0]             action,
   input  lcdw_pkg::dp_status_type status,
   output lcdw_pkg::ctrl_word_type cw,
   output logic                   busy
);

   logic                         running_ff, running_in;
   logic [lcdw_pkg::PC_BITS-1:0] pc_ff, pc_in;
   logic                         taken;

   always_comb begin
      cw = running_ff ? lcdw_pkg::microcode(pc_ff) : lcdw_pkg::CW_NOP;
   end

   always_comb begin
      unique case (cw.cond)
         lcdw_pkg::JMP_BITS_LEFT:   taken = status.bits_left;
         lcdw_pkg::JMP_NOT_NEG:     taken = status.not_neg;
         lcdw_pkg::JMP_LEAD_ZERO:   taken = status.lead_zero;
         lcdw_pkg::JMP_DIGITS_LEFT: taken = status.digits_left;
         default:                   taken = 1'b0;
      endcase
   end

   always_comb begin
      running_in = running_ff;
      pc_in      = pc_ff;
      if (accept) begin
         running_in = (action <= lcdw_pkg::ACT_CLEAR);
         pc_in      = lcdw_pkg::entry_point(action);
      end else if (running_ff) begin
         if (taken) begin
            pc_in = cw.target;
         end else begin
            pc_in      = pc_ff + 1'b1;
            running_in = !cw.done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         pc_ff      <= '0;
      end else begin
         running_ff <= running_in;
         pc_ff      <= pc_in;
      end
   end

   assign busy = running_ff;

endmodule

// File: hdl/lcdw_datapath.sv
// lcdw_datapath: operand registers, shift-and-add-3 decimal converter and
// registered strobe output. Depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcdw_datapath #(
   parameter int NUMBER_DIGITS = lcdw_pkg::NUMBER_DIGITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  lcdw_pkg::req_word_type  req_word,
   input  lcdw_pkg::ctrl_word_type cw,
   output lcdw_pkg::dp_status_type status,
   output logic                    rsp_strobe,
   output lcdw_pkg::rsp_word_type  rsp_word
);

   localparam int BCD_BITS = 4 * NUMBER_DIGITS;
   localparam int CNT_BITS = $clog2(lcdw_pkg::MAG_BITS + 1);
   localparam int REM_BITS = $clog2(NUMBER_DIGITS + 1);

   logic [7:0]                         operand_ff, operand_in;
   logic                               negative_ff, negative_in;
   logic [lcdw_pkg::MAG_BITS-1:0]      mag_ff, mag_in;
   logic [BCD_BITS-1:0]                bcd_ff, bcd_in;
   logic                               ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]                bit_count_ff, bit_count_in;
   logic [REM_BITS-1:0]                remaining_ff, remaining_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   lcdw_pkg::rsp_word_type             rsp_word_ff, rsp_word_in;

   logic [BCD_BITS-1:0]                bcd_adj;
   logic [3:0]                         top_digit;
   logic [7:0]                         emit_byte;
   logic [lcdw_pkg::MAG_BITS-1:0]      num_bits;

   always_comb begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                         : bcd_ff[4*i +: 4];
      end
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];
   assign num_bits  = req_word.number_value;

   always_comb begin
      status.bits_left   = (bit_count_ff != CNT_BITS'(1));
      status.not_neg     = !negative_ff;
      status.digits_left = (remaining_ff > REM_BITS'(1));
      status.lead_zero   = (top_digit == 4'd0) && status.digits_left && !ovf_ff;
   end

   always_comb begin
      operand_in   = operand_ff;
      negative_in  = negative_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      ovf_in       = ovf_ff;
      bit_count_in = bit_count_ff;
      remaining_in = remaining_ff;
      if (accept) begin
         operand_in   = (req_word.action == lcdw_pkg::ACT_GOTO)
                        ? lcdw_pkg::goto_code(req_word.row, req_word.column)
                        : req_word.byte_value;
         negative_in  = num_bits[lcdw_pkg::MAG_BITS-1];
         mag_in       = num_bits[lcdw_pkg::MAG_BITS-1] ? (~num_bits + 1'b1) : num_bits;
         bcd_in       = '0;
         ovf_in       = 1'b0;
         bit_count_in = CNT_BITS'(lcdw_pkg::MAG_BITS);
         remaining_in = REM_BITS'(NUMBER_DIGITS);
      end else begin
         unique case (cw.dp_op)
            lcdw_pkg::DP_DABBLE: begin
               bcd_in       = {bcd_adj[BCD_BITS-2:0], mag_ff[lcdw_pkg::MAG_BITS-1]};
               ovf_in       = ovf_ff | bcd_adj[BCD_BITS-1];
               mag_in       = {mag_ff[lcdw_pkg::MAG_BITS-2:0], 1'b0};
               bit_count_in = bit_count_ff - 1'b1;
            end
            lcdw_pkg::DP_SKIP: begin
               if (status.lead_zero) begin
                  bcd_in       = {bcd_ff[BCD_BITS-5:0], 4'h0};
                  remaining_in = remaining_ff - 1'b1;
               end
            end
            lcdw_pkg::DP_NEXT_DIGIT: begin
               bcd_in       = {bcd_ff[BCD_BITS-5:0], 4'h0};
               remaining_in = remaining_ff - 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (cw.src)
         lcdw_pkg::SRC_OPERAND: emit_byte = operand_ff;
         lcdw_pkg::SRC_DIGIT:   emit_byte = {lcdw_pkg::CHAR_DIGIT_HI, top_digit};
         default:               emit_byte = cw.konst;
      endcase
      rsp_strobe_in               = cw.emit;
      rsp_word_in.register_select = cw.rs;
      rsp_word_in.nibble          = cw.half_lo ? emit_byte[3:0] : emit_byte[7:4];
      rsp_word_in.extra_wait_ms   = cw.wait_ms;
      rsp_word_in.last            = (cw.last_mode == lcdw_pkg::LAST_YES) ||
                                    ((cw.last_mode == lcdw_pkg::LAST_FINAL_DIGIT) &&
                                     !status.digits_left);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      operand_ff   <= operand_in;
      negative_ff  <= negative_in;
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      ovf_ff       <= ovf_in;
      bit_count_ff <= bit_count_in;
      remaining_ff <= remaining_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
